>>> design/sbcd_pkg.sv
// Package for the SCSI bulk command decoder: payload types, opcodes and codes.
`default_nettype none
package sbcd_pkg;

  // Command block as it arrives with one transfer
  typedef struct packed {
    logic [7:0]  opcode;
    logic [3:0]  lun;
    logic        dir_in;
    logic [31:0] host_length;
    logic [7:0]  cdb_b2;
    logic [7:0]  cdb_b3;
    logic [7:0]  cdb_b4;
    logic [7:0]  cdb_b5;
    logic [7:0]  cdb_b7;
    logic [7:0]  cdb_b8;
    logic        card_detect;
    logic        ident_ok;
  } sbcd_in_t;

  // Decision for one command block
  typedef struct packed {
    logic [2:0]  stage;
    logic        csw_status;
    logic        stall_in;
    logic [31:0] lba_out;
    logic [15:0] block_count;
    logic [2:0]  response_kind;
    logic [3:0]  sense_key;
    logic [7:0]  sense_asc;
    logic [31:0] capacity_word;
    logic [31:0] data_length;
  } sbcd_out_t;

  // SCSI opcodes
  localparam logic [7:0] OP_TUR          = 8'h00;
  localparam logic [7:0] OP_REQ_SENSE    = 8'h03;
  localparam logic [7:0] OP_INQUIRY      = 8'h12;
  localparam logic [7:0] OP_START_STOP   = 8'h1B;
  localparam logic [7:0] OP_MODE_SENSE6  = 8'h1A;
  localparam logic [7:0] OP_PREVENT      = 8'h1E;
  localparam logic [7:0] OP_READ_FMT_CAP = 8'h23;
  localparam logic [7:0] OP_READ_CAP     = 8'h25;
  localparam logic [7:0] OP_READ10       = 8'h28;
  localparam logic [7:0] OP_WRITE10      = 8'h2A;
  localparam logic [7:0] OP_WRITE_VERIFY = 8'h2E;
  localparam logic [7:0] OP_VERIFY       = 8'h2F;
  localparam logic [7:0] OP_MODE_SENSE10 = 8'h5A;

  localparam logic [7:0]  MODE_PAGE_ALL = 8'h3F;
  localparam logic [15:0] INQUIRY_LEN   = 16'd36;

  // Transfer stages
  localparam logic [2:0] STG_READ        = 3'd0;
  localparam logic [2:0] STG_READ_DUMMY  = 3'd1;
  localparam logic [2:0] STG_WRITE       = 3'd2;
  localparam logic [2:0] STG_WRITE_DUMMY = 3'd3;
  localparam logic [2:0] STG_STATUS      = 3'd4;
  localparam logic [2:0] STG_DATA_IN     = 3'd5;
  localparam logic [2:0] STG_STALL       = 3'd6;

  // Response kinds
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_INQUIRY   = 3'd1;
  localparam logic [2:0] KIND_SENSE     = 3'd2;
  localparam logic [2:0] KIND_MODE6     = 3'd3;
  localparam logic [2:0] KIND_MODE10    = 3'd4;
  localparam logic [2:0] KIND_FMT_CAP   = 3'd5;
  localparam logic [2:0] KIND_READ_CAP  = 3'd6;

  // CSW status
  localparam logic CSW_PASS = 1'b0;
  localparam logic CSW_FAIL = 1'b1;

  // Pending sense codes
  localparam logic [2:0] SN_NONE     = 3'd0;
  localparam logic [2:0] SN_NOMEDIUM = 3'd1;
  localparam logic [2:0] SN_CHANGED  = 3'd2;
  localparam logic [2:0] SN_BADOP    = 3'd3;
  localparam logic [2:0] SN_BADFIELD = 3'd4;
  localparam logic [2:0] SN_RANGE    = 3'd5;

  // Sense keys and additional sense codes
  localparam logic [3:0] SK_NONE        = 4'h0;
  localparam logic [3:0] SK_NOT_READY   = 4'h2;
  localparam logic [3:0] SK_ILLEGAL     = 4'h5;
  localparam logic [3:0] SK_UNIT_ATTN   = 4'h6;
  localparam logic [7:0] ASC_NONE       = 8'h00;
  localparam logic [7:0] ASC_NO_MEDIUM  = 8'h3A;
  localparam logic [7:0] ASC_CHANGED    = 8'h28;
  localparam logic [7:0] ASC_BAD_OP     = 8'h20;
  localparam logic [7:0] ASC_BAD_FIELD  = 8'h24;
  localparam logic [7:0] ASC_LBA_RANGE  = 8'h21;

endpackage
`default_nettype wire

>>> design/scsi_bulk_command_decoder.sv
// Top level of the SCSI bulk command decoder.
//
//   port group   direction   handshake              payload
//   in_          input       in_valid / in_ready    sbcd_in_t command block
//   out_         output      out_valid / out_ready  sbcd_out_t decision
//   cfg_         input       cfg_wr_en              cfg_wr_data card capacity
//
// One transfer a cycle in each direction while out_ready does not hold back the
// result register; a command block's decision shows on out_ once it has moved
// from the input register through the decode into the result register. Unit
// state (card, sense, LBA, count) updates as the decision is registered, so the
// next block decodes against it. Reset is synchronous on rst_n and clears both
// valid flags and all unit state. A stalled result holds in the result register
// while the input register can still take one more block if it is empty.
`default_nettype none
module scsi_bulk_command_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbcd_pkg::sbcd_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbcd_pkg::sbcd_out_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [31:0]         cfg_wr_data
);
  import sbcd_pkg::*;

  logic      advance;
  logic      fire;
  sbcd_in_t  item;
  sbcd_out_t res;

  sbcd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  sbcd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .res         (res)
  );

  sbcd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> design/sbcd_in_reg.sv
// Input register stage of the SCSI bulk command decoder.
`default_nettype none
module sbcd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbcd_pkg::sbcd_in_t in_data,
  input  wire logic              advance,
  output logic                   fire,
  output sbcd_pkg::sbcd_in_t     item
);
  import sbcd_pkg::*;

  logic     valid_r;
  sbcd_in_t data_r;

  // Take a new transfer when empty or when the held item moves on
  assign in_ready = !valid_r || advance;
  assign fire     = valid_r && advance;
  assign item     = data_r;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

>>> design/sbcd_core.sv
// Decode logic and persistent unit state of the SCSI bulk command decoder.
`default_nettype none
module sbcd_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               fire,
  input  wire sbcd_pkg::sbcd_in_t item,
  output sbcd_pkg::sbcd_out_t     res
);
  import sbcd_pkg::*;

  logic [31:0] capacity_r;
  logic        card_present_r, card_present_nxt;
  logic        unit_stopped_r, unit_stopped_nxt;
  logic        media_changed_r, media_changed_nxt;
  logic [2:0]  pending_sense_r, pending_sense_nxt;
  logic [31:0] lba_r, lba_nxt;
  logic [15:0] count_r, count_nxt;

  logic        track;
  logic        cp_trk, us_trk, mc_trk;
  logic [31:0] cdb_lba;
  logic [15:0] cdb_count;
  logic        rd_op;

  // Card tracking on LUN 0, ahead of the decode
  assign track = (item.lun == 4'd0) && (item.card_detect != card_present_r)
                 && !unit_stopped_r;
  always_comb begin
    cp_trk = card_present_r;
    us_trk = unit_stopped_r;
    mc_trk = media_changed_r;
    if (track) begin
      if (item.ident_ok) begin
        cp_trk = 1'b1;
        mc_trk = 1'b1;
      end else begin
        cp_trk = 1'b0;
        us_trk = 1'b0;
      end
    end
  end

  assign cdb_lba   = {item.cdb_b2, item.cdb_b3, item.cdb_b4, item.cdb_b5};
  assign cdb_count = {item.cdb_b7, item.cdb_b8};
  assign rd_op     = (item.opcode == OP_READ10);

  // Decode the command and work out the next unit state
  always_comb begin
    card_present_nxt  = cp_trk;
    unit_stopped_nxt  = us_trk;
    media_changed_nxt = mc_trk;
    pending_sense_nxt = pending_sense_r;
    lba_nxt           = lba_r;
    count_nxt         = count_r;

    res               = '0;
    res.stage         = STG_STATUS;
    res.csw_status    = CSW_PASS;
    res.data_length   = item.host_length;

    case (item.opcode)
      OP_READ10, OP_WRITE10: begin
        count_nxt = cdb_count;
        if (cp_trk) begin
          if (cdb_lba >= capacity_r) begin
            lba_nxt           = capacity_r;
            res.stage         = rd_op ? STG_READ_DUMMY : STG_WRITE_DUMMY;
            res.csw_status    = CSW_FAIL;
            pending_sense_nxt = SN_RANGE;
          end else begin
            lba_nxt           = cdb_lba;
            res.stage         = rd_op ? STG_READ : STG_WRITE;
            pending_sense_nxt = SN_NONE;
          end
        end else begin
          lba_nxt           = '0;
          res.stage         = rd_op ? STG_READ_DUMMY : STG_WRITE_DUMMY;
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_NOMEDIUM;
        end
      end
      OP_TUR: begin
        if (mc_trk) begin
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_CHANGED;
        end else if (cp_trk) begin
          pending_sense_nxt = SN_NONE;
        end else begin
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_NOMEDIUM;
        end
      end
      OP_REQ_SENSE: begin
        case (pending_sense_r)
          SN_NOMEDIUM: begin
            res.sense_key = SK_NOT_READY;
            res.sense_asc = ASC_NO_MEDIUM;
          end
          SN_CHANGED: begin
            res.sense_key     = SK_UNIT_ATTN;
            res.sense_asc     = ASC_CHANGED;
            media_changed_nxt = 1'b0;
          end
          SN_BADOP: begin
            res.sense_key = SK_ILLEGAL;
            res.sense_asc = ASC_BAD_OP;
          end
          SN_BADFIELD: begin
            res.sense_key = SK_ILLEGAL;
            res.sense_asc = ASC_BAD_FIELD;
          end
          SN_RANGE: begin
            res.sense_key = SK_ILLEGAL;
            res.sense_asc = ASC_LBA_RANGE;
          end
          default: begin
            res.sense_key = SK_NONE;
            res.sense_asc = ASC_NONE;
          end
        endcase
        pending_sense_nxt = SN_NONE;
        res.response_kind = KIND_SENSE;
        res.stage         = STG_DATA_IN;
      end
      OP_INQUIRY: begin
        res.response_kind = KIND_INQUIRY;
        res.stage         = STG_DATA_IN;
        res.data_length   = {item.host_length[31:16], INQUIRY_LEN};
      end
      OP_MODE_SENSE6, OP_MODE_SENSE10: begin
        if (item.cdb_b2 != MODE_PAGE_ALL) begin
          res.stage         = STG_STALL;
          res.stall_in      = 1'b1;
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_BADFIELD;
        end else begin
          res.response_kind = (item.opcode == OP_MODE_SENSE6) ? KIND_MODE6 : KIND_MODE10;
          res.stage         = STG_DATA_IN;
        end
      end
      OP_PREVENT: begin
        if (item.cdb_b4[0]) begin
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_BADFIELD;
        end
      end
      OP_START_STOP: begin
        card_present_nxt = item.cdb_b4[0];
        unit_stopped_nxt = !item.cdb_b4[0];
      end
      OP_READ_FMT_CAP, OP_READ_CAP: begin
        if (cp_trk) begin
          if (item.opcode == OP_READ_FMT_CAP) begin
            res.response_kind = KIND_FMT_CAP;
            res.capacity_word = capacity_r;
          end else begin
            res.response_kind = KIND_READ_CAP;
            res.capacity_word = capacity_r - 32'd1;
          end
          res.stage         = STG_DATA_IN;
          pending_sense_nxt = SN_NONE;
        end else begin
          res.stage         = STG_STALL;
          res.stall_in      = 1'b1;
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_NOMEDIUM;
        end
        if (mc_trk) begin
          res.csw_status    = CSW_FAIL;
          pending_sense_nxt = SN_CHANGED;
        end
      end
      OP_VERIFY: begin
        pending_sense_nxt = SN_NONE;
      end
      OP_WRITE_VERIFY: begin
        count_nxt         = cdb_count;
        res.stage         = STG_WRITE_DUMMY;
        pending_sense_nxt = SN_NONE;
      end
      default: begin
        res.stage         = STG_STALL;
        res.stall_in      = item.dir_in;
        res.csw_status    = CSW_FAIL;
        pending_sense_nxt = SN_BADOP;
      end
    endcase

    res.lba_out     = lba_nxt;
    res.block_count = count_nxt;
  end

  // Hold the card size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Advance unit state with each decoded transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_present_r  <= 1'b0;
      unit_stopped_r  <= 1'b0;
      media_changed_r <= 1'b0;
      pending_sense_r <= SN_NONE;
      lba_r           <= '0;
      count_r         <= '0;
    end else if (fire) begin
      card_present_r  <= card_present_nxt;
      unit_stopped_r  <= unit_stopped_nxt;
      media_changed_r <= media_changed_nxt;
      pending_sense_r <= pending_sense_nxt;
      lba_r           <= lba_nxt;
      count_r         <= count_nxt;
    end
  end

  // Reporting a media change clears the flag
  a_sense_clears_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.opcode == OP_REQ_SENSE) && (pending_sense_r == SN_CHANGED)
    |=> !media_changed_r && (pending_sense_r == SN_NONE))
    else $error("media changed flag survived REQUEST SENSE");

  // A stop leaves the unit stopped with no card
  a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.opcode == OP_START_STOP) && !item.cdb_b4[0]
    |=> unit_stopped_r && !card_present_r)
    else $error("START STOP did not stop the unit");

  // A sector transfer only runs inside the card
  a_lba_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ((res.stage == STG_READ) || (res.stage == STG_WRITE))
    |-> (res.lba_out < capacity_r))
    else $error("sector transfer outside card capacity");

  // Unit state holds between transfers
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pending_sense_r) && $stable(lba_r) && $stable(count_r))
    else $error("unit state changed without a transfer");

endmodule
`default_nettype wire

>>> design/sbcd_out_reg.sv
// Result register stage of the SCSI bulk command decoder.
`default_nettype none
module sbcd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire sbcd_pkg::sbcd_out_t res,
  output logic                     advance,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbcd_pkg::sbcd_out_t      out_data
);
  import sbcd_pkg::*;

  logic      valid_r;
  sbcd_out_t data_r;

  // Room for a new result when empty or when the held one leaves
  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= fire;
    end
  end

  // Capture result
  always_ff @(posedge clk) begin
    if (fire) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_scsi_bulk_command_decoder.sv
// Testbench for the SCSI bulk command decoder: directed table, then random command blocks.
`timescale 1ns / 100ps
`default_nettype none
module tb_scsi_bulk_command_decoder;
  import sbcd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int SEG_ITEMS    = 190;
  localparam int NUM_SEGS     = 6;

  // One line of the directed table
  typedef struct {
    sbcd_in_t  cmd;
    bit        typed;
    sbcd_out_t dec;
  } cmd_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  sbcd_in_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  sbcd_out_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;

  // Unit state as the decoder should hold it
  logic        card_in_slot;
  logic        unit_parked;
  logic        media_swapped;
  logic [2:0]  sense_code;
  logic [31:0] lba_now;
  logic [15:0] count_now;
  logic [31:0] capacity_now;

  sbcd_out_t decision_q[$];
  cmd_row_t  directed_rows[$];

  scsi_bulk_command_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Decode one command block against the unit state and advance that state
  function automatic sbcd_out_t decode_command(input sbcd_in_t c);
    sbcd_out_t   d;
    logic [31:0] lba;
    logic        rd;
    d = '0;
    d.stage = STG_STATUS;
    d.csw_status = CSW_PASS;
    d.data_length = c.host_length;
    lba = {c.cdb_b2, c.cdb_b3, c.cdb_b4, c.cdb_b5};
    rd = (c.opcode == OP_READ10);

    // Follow card insertion and removal on LUN 0
    if (c.lun == 4'd0 && c.card_detect != card_in_slot && !unit_parked) begin
      if (!c.ident_ok) begin
        card_in_slot = 1'b0;
        unit_parked = 1'b0;
      end else begin
        media_swapped = 1'b1;
        card_in_slot = 1'b1;
      end
    end

    case (c.opcode)
      OP_READ10, OP_WRITE10: begin
        count_now = {c.cdb_b7, c.cdb_b8};
        if (card_in_slot) begin
          if (lba >= capacity_now) begin
            lba_now = capacity_now;
            d.stage = rd ? STG_READ_DUMMY : STG_WRITE_DUMMY;
            d.csw_status = CSW_FAIL;
            sense_code = SN_RANGE;
          end else begin
            lba_now = lba;
            d.stage = rd ? STG_READ : STG_WRITE;
            sense_code = SN_NONE;
          end
        end else begin
          lba_now = '0;
          d.stage = rd ? STG_READ_DUMMY : STG_WRITE_DUMMY;
          d.csw_status = CSW_FAIL;
          sense_code = SN_NOMEDIUM;
        end
      end
      OP_TUR: begin
        if (card_in_slot) begin
          sense_code = SN_NONE;
        end else begin
          d.csw_status = CSW_FAIL;
          sense_code = SN_NOMEDIUM;
        end
        if (media_swapped) begin
          d.csw_status = CSW_FAIL;
          sense_code = SN_CHANGED;
        end
      end
      OP_REQ_SENSE: begin
        case (sense_code)
          SN_NOMEDIUM: begin
            d.sense_key = SK_NOT_READY;
            d.sense_asc = ASC_NO_MEDIUM;
          end
          SN_CHANGED: begin
            d.sense_key = SK_UNIT_ATTN;
            d.sense_asc = ASC_CHANGED;
            media_swapped = 1'b0;
          end
          SN_BADOP: begin
            d.sense_key = SK_ILLEGAL;
            d.sense_asc = ASC_BAD_OP;
          end
          SN_BADFIELD: begin
            d.sense_key = SK_ILLEGAL;
            d.sense_asc = ASC_BAD_FIELD;
          end
          SN_RANGE: begin
            d.sense_key = SK_ILLEGAL;
            d.sense_asc = ASC_LBA_RANGE;
          end
          default: begin
            d.sense_key = SK_NONE;
            d.sense_asc = ASC_NONE;
          end
        endcase
        sense_code = SN_NONE;
        d.response_kind = KIND_SENSE;
        d.stage = STG_DATA_IN;
      end
      OP_INQUIRY: begin
        d.response_kind = KIND_INQUIRY;
        d.stage = STG_DATA_IN;
        d.data_length[15:0] = INQUIRY_LEN;
      end
      OP_MODE_SENSE6, OP_MODE_SENSE10: begin
        if (c.cdb_b2 != MODE_PAGE_ALL) begin
          d.stage = STG_STALL;
          d.stall_in = 1'b1;
          d.csw_status = CSW_FAIL;
          sense_code = SN_BADFIELD;
        end else begin
          d.response_kind = (c.opcode == OP_MODE_SENSE6) ? KIND_MODE6 : KIND_MODE10;
          d.stage = STG_DATA_IN;
        end
      end
      OP_PREVENT: begin
        if (c.cdb_b4[0]) begin
          d.csw_status = CSW_FAIL;
          sense_code = SN_BADFIELD;
        end
      end
      OP_START_STOP: begin
        card_in_slot = c.cdb_b4[0];
        unit_parked = !c.cdb_b4[0];
      end
      OP_READ_FMT_CAP, OP_READ_CAP: begin
        if (card_in_slot) begin
          if (c.opcode == OP_READ_FMT_CAP) begin
            d.response_kind = KIND_FMT_CAP;
            d.capacity_word = capacity_now;
          end else begin
            d.response_kind = KIND_READ_CAP;
            d.capacity_word = capacity_now - 32'd1;
          end
          d.stage = STG_DATA_IN;
          sense_code = SN_NONE;
        end else begin
          d.stage = STG_STALL;
          d.stall_in = 1'b1;
          d.csw_status = CSW_FAIL;
          sense_code = SN_NOMEDIUM;
        end
        if (media_swapped) begin
          d.csw_status = CSW_FAIL;
          sense_code = SN_CHANGED;
        end
      end
      OP_VERIFY: begin
        sense_code = SN_NONE;
      end
      OP_WRITE_VERIFY: begin
        count_now = {c.cdb_b7, c.cdb_b8};
        d.stage = STG_WRITE_DUMMY;
        sense_code = SN_NONE;
      end
      default: begin
        d.stage = STG_STALL;
        d.stall_in = c.dir_in;
        d.csw_status = CSW_FAIL;
        sense_code = SN_BADOP;
      end
    endcase

    d.lba_out = lba_now;
    d.block_count = count_now;
    return d;
  endfunction

  function automatic sbcd_in_t make_cmd(input logic [7:0] op, input logic [3:0] lun,
                                        input logic dir, input logic [31:0] hlen,
                                        input logic [31:0] lba, input logic [7:0] b7,
                                        input logic [7:0] b8, input logic det,
                                        input logic ident);
    sbcd_in_t c;
    c.opcode = op;
    c.lun = lun;
    c.dir_in = dir;
    c.host_length = hlen;
    {c.cdb_b2, c.cdb_b3, c.cdb_b4, c.cdb_b5} = lba;
    c.cdb_b7 = b7;
    c.cdb_b8 = b8;
    c.card_detect = det;
    c.ident_ok = ident;
    return c;
  endfunction

  function automatic sbcd_out_t make_dec(input logic [2:0] stage, input logic csw,
                                         input logic stall, input logic [31:0] lba,
                                         input logic [15:0] cnt, input logic [2:0] kind,
                                         input logic [3:0] key, input logic [7:0] asc,
                                         input logic [31:0] capw, input logic [31:0] dlen);
    sbcd_out_t d;
    d.stage = stage;
    d.csw_status = csw;
    d.stall_in = stall;
    d.lba_out = lba;
    d.block_count = cnt;
    d.response_kind = kind;
    d.sense_key = key;
    d.sense_asc = asc;
    d.capacity_word = capw;
    d.data_length = dlen;
    return d;
  endfunction

  task automatic add_row(input sbcd_in_t c, input bit typed, input sbcd_out_t d);
    cmd_row_t r;
    r.cmd = c;
    r.typed = typed;
    r.dec = d;
    directed_rows.push_back(r);
  endtask

  // Present one command block, hold it until the transfer, then log its decision
  task automatic send_cmd(input sbcd_in_t cmd, input bit typed, input sbcd_out_t typed_dec);
    sbcd_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = decode_command(cmd);
    decision_q.push_back(typed ? typed_dec : predicted);
  endtask

  // Drain the decoder, then load a new card capacity
  task automatic write_capacity(input logic [31:0] cap);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity_now = cap;
  endtask

  // Receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each decision transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    sbcd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decision_q.size() == 0) begin
        $error("decision transfer with no command pending");
        fail_count++;
      end else begin
        want = decision_q.pop_front();
        if (out_data.stage !== want.stage) begin
          $error("stage: expected %0d, got %0d", want.stage, out_data.stage);
          fail_count++;
        end
        if (out_data.csw_status !== want.csw_status) begin
          $error("csw_status: expected %0d, got %0d", want.csw_status, out_data.csw_status);
          fail_count++;
        end
        if (out_data.stall_in !== want.stall_in) begin
          $error("stall_in: expected %0d, got %0d", want.stall_in, out_data.stall_in);
          fail_count++;
        end
        if (out_data.lba_out !== want.lba_out) begin
          $error("lba_out: expected %h, got %h", want.lba_out, out_data.lba_out);
          fail_count++;
        end
        if (out_data.block_count !== want.block_count) begin
          $error("block_count: expected %h, got %h", want.block_count, out_data.block_count);
          fail_count++;
        end
        if (out_data.response_kind !== want.response_kind) begin
          $error("response_kind: expected %0d, got %0d", want.response_kind,
                 out_data.response_kind);
          fail_count++;
        end
        if (out_data.sense_key !== want.sense_key) begin
          $error("sense_key: expected %h, got %h", want.sense_key, out_data.sense_key);
          fail_count++;
        end
        if (out_data.sense_asc !== want.sense_asc) begin
          $error("sense_asc: expected %h, got %h", want.sense_asc, out_data.sense_asc);
          fail_count++;
        end
        if (out_data.capacity_word !== want.capacity_word) begin
          $error("capacity_word: expected %h, got %h", want.capacity_word,
                 out_data.capacity_word);
          fail_count++;
        end
        if (out_data.data_length !== want.data_length) begin
          $error("data_length: expected %h, got %h", want.data_length, out_data.data_length);
          fail_count++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[scsi_bulk_command_decoder] ERROR");
    $finish;
  end

  initial begin : stimulus
    sbcd_out_t none_dec;
    none_dec = '0;

    // Unit state after reset
    card_in_slot = 1'b0;
    unit_parked = 1'b0;
    media_swapped = 1'b0;
    sense_code = SN_NONE;
    lba_now = '0;
    count_now = '0;
    capacity_now = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 77;
    write_capacity(32'h0000_0000);

    // No card: not ready, then sense reports it, then nothing pending
    add_row(make_cmd(OP_TUR, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
            make_dec(STG_STATUS, CSW_FAIL, 1'b0, 32'd0, 16'd0, KIND_NONE, SK_NONE,
                     ASC_NONE, 32'd0, 32'd0));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_SENSE,
                           SK_NOT_READY, ASC_NO_MEDIUM, 32'd0, 32'd18));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_SENSE,
                           SK_NONE, ASC_NONE, 32'd0, 32'd18));
    // Unknown opcodes stall the endpoint that the direction names
    add_row(make_cmd(8'hFF, 4'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0,
                     1'b0), 1'b1,
            make_dec(STG_STALL, CSW_FAIL, 1'b1, 32'd0, 16'd0, KIND_NONE, SK_NONE, ASC_NONE,
                     32'd0, 32'hFFFF_FFFF));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_SENSE,
                           SK_ILLEGAL, ASC_BAD_OP, 32'd0, 32'd18));
    add_row(make_cmd(8'h01, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
            make_dec(STG_STALL, CSW_FAIL, 1'b0, 32'd0, 16'd0, KIND_NONE, SK_NONE, ASC_NONE,
                     32'd0, 32'd0));
    // Mode sense with a page other than all pages
    add_row(make_cmd(OP_MODE_SENSE6, 4'd0, 1'b0, 32'd192, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_STALL, CSW_FAIL, 1'b1, 32'd0, 16'd0, KIND_NONE, SK_NONE,
                           ASC_NONE, 32'd0, 32'd192));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_SENSE,
                           SK_ILLEGAL, ASC_BAD_FIELD, 32'd0, 32'd18));
    // Capacity without a card stalls bulk in
    add_row(make_cmd(OP_READ_CAP, 4'd0, 1'b1, 32'd8, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0), 1'b1,
            make_dec(STG_STALL, CSW_FAIL, 1'b1, 32'd0, 16'd0, KIND_NONE, SK_NONE, ASC_NONE,
                     32'd0, 32'd8));
    add_row(make_cmd(OP_INQUIRY, 4'd0, 1'b1, 32'hFFFF_FFFF, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_INQUIRY, SK_NONE,
                           ASC_NONE, 32'd0, 32'hFFFF_0024));
    add_row(make_cmd(OP_READ10, 4'd0, 1'b1, 32'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, 1'b0),
            1'b1, make_dec(STG_READ_DUMMY, CSW_FAIL, 1'b0, 32'd0, 16'hFFFF, KIND_NONE,
                           SK_NONE, ASC_NONE, 32'd0, 32'd0));
    // Card goes in: media changed until sense reports it
    add_row(make_cmd(OP_TUR, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1), 1'b1,
            make_dec(STG_STATUS, CSW_FAIL, 1'b0, 32'd0, 16'hFFFF, KIND_NONE, SK_NONE,
                     ASC_NONE, 32'd0, 32'd0));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'hFFFF, KIND_SENSE,
                           SK_UNIT_ATTN, ASC_CHANGED, 32'd0, 32'd18));
    // Out of range LBA clamps to the capacity
    add_row(make_cmd(OP_READ10, 4'd0, 1'b1, 32'd512, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b1, make_dec(STG_READ_DUMMY, CSW_FAIL, 1'b0, 32'd0, 16'd0, KIND_NONE, SK_NONE,
                           ASC_NONE, 32'd0, 32'd512));
    add_row(make_cmd(OP_REQ_SENSE, 4'd0, 1'b1, 32'd18, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b1, make_dec(STG_DATA_IN, CSW_PASS, 1'b0, 32'd0, 16'd0, KIND_SENSE,
                           SK_ILLEGAL, ASC_LBA_RANGE, 32'd0, 32'd18));
    // Remaining operations, checked by the decode model
    add_row(make_cmd(OP_WRITE10, 4'd0, 1'b0, 32'd512, 32'd0, 8'h00, 8'h01, 1'b1, 1'b1),
            1'b0, none_dec);
    add_row(make_cmd(OP_READ_FMT_CAP, 4'd0, 1'b1, 32'd12, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b0, none_dec);
    add_row(make_cmd(OP_READ_CAP, 4'd0, 1'b1, 32'd8, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b0, none_dec);
    add_row(make_cmd(OP_MODE_SENSE6, 4'd0, 1'b1, 32'd4, 32'h3F00_0000, 8'h00, 8'h00, 1'b1,
                     1'b1), 1'b0, none_dec);
    add_row(make_cmd(OP_MODE_SENSE10, 4'd0, 1'b1, 32'd8, 32'h3F00_0000, 8'h00, 8'h00, 1'b1,
                     1'b1), 1'b0, none_dec);
    add_row(make_cmd(OP_PREVENT, 4'd0, 1'b0, 32'd0, 32'h0000_0100, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b0, none_dec);
    add_row(make_cmd(OP_VERIFY, 4'd0, 1'b0, 32'd0, 32'd7, 8'h00, 8'h08, 1'b1, 1'b1), 1'b0,
            none_dec);
    add_row(make_cmd(OP_WRITE_VERIFY, 4'd0, 1'b0, 32'd4096, 32'd3, 8'h12, 8'h34, 1'b1, 1'b1),
            1'b0, none_dec);
    // Stop the unit: tracking holds off until it is started again
    add_row(make_cmd(OP_START_STOP, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1),
            1'b0, none_dec);
    add_row(make_cmd(OP_TUR, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b1, 1'b1), 1'b0,
            none_dec);
    add_row(make_cmd(OP_START_STOP, 4'd0, 1'b0, 32'd0, 32'h0000_0100, 8'h00, 8'h00, 1'b1,
                     1'b1), 1'b0, none_dec);
    // Other LUNs skip tracking; then removal and a failed identification
    add_row(make_cmd(OP_TUR, 4'd15, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
            none_dec);
    add_row(make_cmd(OP_TUR, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b0, 1'b0), 1'b0,
            none_dec);
    add_row(make_cmd(OP_TUR, 4'd0, 1'b0, 32'd0, 32'd0, 8'h00, 8'h00, 1'b1, 1'b0), 1'b0,
            none_dec);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].dec);
    end
    in_valid <= 1'b0;

    // Random segments: new capacity and idling mode for each
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: write_capacity(32'hFFFF_FFFF);
        1: write_capacity(32'd1);
        2: write_capacity($urandom_range(5000, 1));
        3: write_capacity($urandom());
        4: write_capacity(32'h0000_0800);
        default: write_capacity(32'h0000_0000);
      endcase
      case (seg / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      for (int n = 0; n < SEG_ITEMS; n++) begin : gen
        sbcd_in_t    cmd;
        logic [31:0] lba;
        case ($urandom_range(15))
          0: cmd.opcode = OP_TUR;
          1: cmd.opcode = OP_REQ_SENSE;
          2: cmd.opcode = OP_INQUIRY;
          3: cmd.opcode = OP_START_STOP;
          4: cmd.opcode = OP_MODE_SENSE6;
          5: cmd.opcode = OP_PREVENT;
          6: cmd.opcode = OP_READ_FMT_CAP;
          7: cmd.opcode = OP_READ_CAP;
          8: cmd.opcode = OP_READ10;
          9: cmd.opcode = OP_WRITE10;
          10: cmd.opcode = OP_WRITE_VERIFY;
          11: cmd.opcode = OP_VERIFY;
          12: cmd.opcode = OP_MODE_SENSE10;
          default: cmd.opcode = 8'($urandom_range(255));
        endcase
        // Aim the LBA inside, at and just past the card end, or anywhere at random
        case ($urandom_range(9))
          0, 1, 2, 3, 4: lba = (capacity_now == 0) ? 32'd0 : $urandom_range(capacity_now - 1);
          5: lba = capacity_now - 32'd1;
          6: lba = capacity_now;
          7: lba = capacity_now + 32'd1;
          default: lba = $urandom();
        endcase
        {cmd.cdb_b2, cmd.cdb_b3, cmd.cdb_b4, cmd.cdb_b5} = lba;
        if ((cmd.opcode == OP_MODE_SENSE6 || cmd.opcode == OP_MODE_SENSE10) &&
            $urandom_range(9) < 7) begin
          cmd.cdb_b2 = MODE_PAGE_ALL;
        end
        cmd.lun = ($urandom_range(4) != 0) ? 4'd0 : 4'($urandom_range(15));
        cmd.dir_in = 1'($urandom_range(1));
        cmd.host_length = $urandom_range(1) ? $urandom() : $urandom_range(4096);
        cmd.cdb_b7 = 8'($urandom_range(255));
        cmd.cdb_b8 = 8'($urandom_range(255));
        // Mostly hold the socket level; flip it now and then
        cmd.card_detect = ($urandom_range(99) < 15) ? !card_in_slot : card_in_slot;
        cmd.ident_ok = ($urandom_range(99) < 80);
        send_cmd(cmd, 1'b0, none_dec);
      end
      in_valid <= 1'b0;
    end

    // Drain, let the pipeline settle, then report
    while (decision_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("[scsi_bulk_command_decoder] OK");
    end else begin
      $display("[scsi_bulk_command_decoder] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
design/sbcd_pkg.sv
design/sbcd_in_reg.sv
design/sbcd_core.sv
design/sbcd_out_reg.sv
design/scsi_bulk_command_decoder.sv
sim/tb_scsi_bulk_command_decoder.sv
